>>> hw/rtl/osm_pkg.sv
// shared constants and codes for the order statistic multiset unit
// no dependencies
package osm_pkg;

  localparam int KEY_BITS   = 16;
  localparam int COUNT_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int TOTAL_W    = 16;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int S_DATA_W   = 2 * FIELD_W;
  localparam int M_DATA_W   = 3 * FIELD_W;

  localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_ERASE  = 2'd1,
    REQ_RANK   = 2'd2,
    REQ_SELECT = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

endpackage

>>> hw/rtl/order_statistic_multiset_unit.sv
// Order statistic multiset: insert, erase, rank and select over 2^KEY_BITS keys. Per-key counts
// and a binary indexed prefix tree live in two synchronous rams. After reset a clearing pass
// zeroes both rams, one entry a cycle, with s_tready low. One transaction is worked at a time;
// the cost is set by the tree ram's single read port.
// A rank query reads popcount(key) tree nodes, at most KEY_BITS (one tree read a cycle,
// pipelined). An insert or erase adds a count read and a pipelined read-modify-write walk up the
// tree; the walk up and the query after it visit KEY_BITS+1 nodes together; a full insert or an
// absent erase skips the walk. A select walks down the tree with a read and a compare per level
// over KEY_BITS+1 levels; a select past the end skips the walk.
// depends on osm_pkg and osm_ram
module order_statistic_multiset_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [osm_pkg::S_DATA_W-1:0]   s_tdata,   // key, index
  input  logic [osm_pkg::REQ_W-1:0]      s_tuser,   // req_type
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [osm_pkg::M_DATA_W-1:0]   m_tdata,   // rank, total, selected_key
  output logic [osm_pkg::STATUS_W-1:0]   m_tuser    // status
);
  import osm_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_CNT     = 8'b0000_0100,
    S_UPD     = 8'b0000_1000,
    S_QRY     = 8'b0001_0000,
    S_SEL_RD  = 8'b0010_0000,
    S_SEL_CHK = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  localparam logic [KEY_BITS+1:0] NODE_LIMIT = {2'b01, {KEY_BITS{1'b0}}};
  localparam logic [KEY_BITS:0]   STEP_INIT  = {1'b1, {KEY_BITS{1'b0}}};

  state_t               state;
  req_t                 req;
  logic [KEY_BITS-1:0]  key_r;
  logic [FIELD_W-1:0]   idx_r;
  logic [TOTAL_W-1:0]   stored_total;
  logic [KEY_BITS+1:0]  node;
  logic                 rd_pend;
  logic [KEY_BITS-1:0]  rd_node;
  logic                 up;
  logic [TOTAL_W-1:0]   sum;
  logic [KEY_BITS:0]    pos;
  logic [KEY_BITS:0]    step;
  logic [FIELD_W-1:0]   rem;
  status_t              status_r;
  logic [KEY_BITS-1:0]  clr_addr;

  logic [KEY_BITS-1:0]   key_in;
  logic [FIELD_W-1:0]    idx_in;
  req_t                  req_in;
  logic                  node_ok;
  logic [KEY_BITS-1:0]   node_addr;
  logic [KEY_BITS+1:0]   node_low;
  logic [KEY_BITS:0]     sel_nxt;
  logic                  cnt_full;
  logic                  do_upd;
  logic [FIELD_W-1:0]    res_rank;
  logic [FIELD_W-1:0]    res_sel;

  logic                  cnt_wr_en;
  logic [KEY_BITS-1:0]   cnt_wr_addr;
  logic [COUNT_BITS-1:0] cnt_wr_data;
  logic                  cnt_rd_en;
  logic [COUNT_BITS-1:0] cnt_rd_data;
  logic                  tree_wr_en;
  logic [KEY_BITS-1:0]   tree_wr_addr;
  logic [TOTAL_W-1:0]    tree_wr_data;
  logic                  tree_rd_en;
  logic [KEY_BITS-1:0]   tree_rd_addr;
  logic [TOTAL_W-1:0]    tree_rd_data;

  assign key_in   = KEY_BITS'(s_tdata[FIELD_W-1:0]);
  assign idx_in   = s_tdata[2*FIELD_W-1:FIELD_W];
  assign req_in   = req_t'(s_tuser);
  assign s_tready = (state == S_IDLE);

  // tree node n lives at address n-1
  assign node_ok   = (node != '0) && (node <= NODE_LIMIT);
  assign node_addr = KEY_BITS'(node - 1'b1);
  assign node_low  = node & (~node + 1'b1);
  assign sel_nxt   = pos + step;

  assign cnt_full = (stored_total == TOTAL_MAX) || (cnt_rd_data == COUNT_MAX);
  assign do_upd   = (req == REQ_INSERT) ? !cnt_full : (cnt_rd_data != '0);

  // select: keys below the chosen one are what the descent consumed from the index
  assign res_rank = (req == REQ_SELECT) ? (idx_r - rem) : FIELD_W'(sum);
  assign res_sel  = (req == REQ_SELECT) ? FIELD_W'(pos[KEY_BITS-1:0]) : '0;

  always_comb begin
    cnt_rd_en    = s_tvalid && s_tready;
    cnt_wr_en    = 1'b0;
    cnt_wr_addr  = key_r;
    cnt_wr_data  = (req == REQ_INSERT) ? cnt_rd_data + COUNT_BITS'(1)
                                       : cnt_rd_data - COUNT_BITS'(1);
    tree_rd_en   = 1'b0;
    tree_rd_addr = node_addr;
    tree_wr_en   = 1'b0;
    tree_wr_addr = rd_node;
    tree_wr_data = up ? tree_rd_data + TOTAL_W'(1) : tree_rd_data - TOTAL_W'(1);
    unique case (state)
      S_CLEAR: begin
        cnt_wr_en    = 1'b1;
        cnt_wr_addr  = clr_addr;
        cnt_wr_data  = '0;
        tree_wr_en   = 1'b1;
        tree_wr_addr = clr_addr;
        tree_wr_data = '0;
      end
      S_CNT: begin
        cnt_wr_en = do_upd;
      end
      S_UPD: begin
        // read the next node while the previous one is written back
        tree_rd_en = node_ok;
        tree_wr_en = rd_pend;
      end
      S_QRY: begin
        tree_rd_en = (node != '0);
      end
      S_SEL_RD: begin
        tree_rd_en   = 1'b1;
        tree_rd_addr = KEY_BITS'(sel_nxt - 1'b1);
      end
      S_IDLE, S_SEL_CHK, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  osm_ram #(.ADDR_W(KEY_BITS), .DATA_W(COUNT_BITS)) u_count_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_en   (cnt_rd_en),
    .rd_addr (key_in),
    .rd_data (cnt_rd_data)
  );

  osm_ram #(.ADDR_W(KEY_BITS), .DATA_W(TOTAL_W)) u_tree_ram (
    .clk     (clk),
    .wr_en   (tree_wr_en),
    .wr_addr (tree_wr_addr),
    .wr_data (tree_wr_data),
    .rd_en   (tree_rd_en),
    .rd_addr (tree_rd_addr),
    .rd_data (tree_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      stored_total <= '0;
      rd_pend      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // in S_DONE the result register is reloaded instead
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            req      <= req_in;
            key_r    <= key_in;
            idx_r    <= idx_in;
            sum      <= '0;
            rd_pend  <= 1'b0;
            status_r <= ST_OK;
            pos      <= '0;
            step     <= STEP_INIT;
            rem      <= idx_in;
            unique case (req_in)
              REQ_INSERT, REQ_ERASE: begin
                state <= S_CNT;
              end
              REQ_RANK: begin
                node  <= (KEY_BITS+2)'(key_in);
                state <= S_QRY;
              end
              REQ_SELECT: begin
                if (idx_in >= stored_total) begin
                  status_r <= ST_RANGE;
                  state    <= S_DONE;
                end else begin
                  state <= S_SEL_RD;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_CNT: begin
          if (do_upd) begin
            stored_total <= (req == REQ_INSERT) ? stored_total + 1'b1 : stored_total - 1'b1;
            up           <= (req == REQ_INSERT);
            node         <= (KEY_BITS+2)'(key_r) + 1'b1;
            state        <= S_UPD;
          end else begin
            status_r <= (req == REQ_INSERT) ? ST_FULL : ST_ABSENT;
            node     <= (KEY_BITS+2)'(key_r);
            state    <= S_QRY;
          end
        end
        S_UPD: begin
          rd_pend <= node_ok;
          rd_node <= node_addr;
          if (node_ok) begin
            node <= node + node_low;
          end else begin
            // last write-back goes out this cycle
            node  <= (KEY_BITS+2)'(key_r);
            state <= S_QRY;
          end
        end
        S_QRY: begin
          rd_pend <= (node != '0);
          if (node != '0) begin
            node <= node & (node - 1'b1);
          end
          if (rd_pend) begin
            sum <= sum + tree_rd_data;
          end
          if ((node == '0) && !rd_pend) begin
            state <= S_DONE;
          end
        end
        S_SEL_RD: begin
          state <= S_SEL_CHK;
        end
        S_SEL_CHK: begin
          if (tree_rd_data <= rem) begin
            pos <= sel_nxt;
            rem <= rem - tree_rd_data;
          end
          step <= step >> 1;
          state <= step[0] ? S_DONE : S_SEL_RD;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_sel, FIELD_W'(stored_total), res_rank};
            m_tuser  <= status_r;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while one is in progress");

  a_total_from_cnt: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (stored_total != $past(stored_total)) |-> $past(state == S_CNT))
    else $error("stored total changed outside the count update");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result presented without finishing a request");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_RANGE) |->
      (m_tdata[FIELD_W-1:0] == '0) && (m_tdata[M_DATA_W-1:2*FIELD_W] == '0))
    else $error("out of range select with nonzero rank or key");
`endif

endmodule

>>> hw/rtl/osm_ram.sv
// simple dual port synchronous ram, one write and one registered read port
// no dependencies
module osm_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// testbench for order_statistic_multiset_unit: random and directed insert, erase, rank
// and select traffic, each result checked against a shadow count store with a prefix tree
// depends on osm_pkg and the rtl of the unit
module tb_top;
  import osm_pkg::*;

  // the clearing pass after reset alone counts as quiet
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int NUM_KEYS       = 1 << KEY_BITS;

  typedef struct packed {
    logic [FIELD_W-1:0] rank;
    logic [FIELD_W-1:0] total;
    logic [FIELD_W-1:0] selected_key;
    status_t            status;
  } result_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata  = '0;   // key, index
  logic [REQ_W-1:0]      s_tuser  = '0;   // req_type
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;         // rank, total, selected_key
  logic [STATUS_W-1:0]   m_tuser;         // status

  // shadow of the store
  bit [COUNT_BITS-1:0]   key_copies [NUM_KEYS];
  int unsigned           prefix_tree [NUM_KEYS + 1];
  bit [TOTAL_W-1:0]      stored_total;

  result_t               pending_results [$];
  result_t               oldest_result;
  logic [FIELD_W-1:0]    key_pool [16];

  int  fail_count      = 0;
  int  quiet_cycles    = 0;
  int  stall_left      = 0;
  int  hold_left       = 0;
  int  hold_request    = 0;
  bit  sender_idle_en  = 1'b1;
  bit  receiver_idle_en = 1'b1;

  order_statistic_multiset_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic void tree_adjust(int unsigned key, bit up);
    int unsigned i;
    i = key + 1;
    while (i <= NUM_KEYS) begin
      if (up) prefix_tree[i] = prefix_tree[i] + 1;
      else prefix_tree[i] = prefix_tree[i] - 1;
      i = i + (i & (~i + 1));
    end
  endfunction

  // stored keys strictly below key
  function automatic int unsigned keys_below(int unsigned key);
    int unsigned i;
    int unsigned sum;
    i   = key;
    sum = 0;
    while (i > 0) begin
      sum = sum + prefix_tree[i];
      i   = i & (i - 1);
    end
    return sum;
  endfunction

  function automatic result_t apply_request(req_t req, logic [FIELD_W-1:0] key,
                                            logic [FIELD_W-1:0] idx);
    result_t     res;
    int unsigned pos;
    int unsigned rem;
    int unsigned step;
    res.rank         = '0;
    res.selected_key = '0;
    res.status       = ST_OK;
    case (req)
      REQ_INSERT: begin
        if (stored_total == TOTAL_MAX || key_copies[key] == COUNT_MAX) begin
          res.status = ST_FULL;
        end else begin
          key_copies[key]++;
          stored_total++;
          tree_adjust(32'(key), 1'b1);
        end
        res.rank = FIELD_W'(keys_below(32'(key)));
      end
      REQ_ERASE: begin
        if (key_copies[key] == 0) begin
          res.status = ST_ABSENT;
        end else begin
          key_copies[key]--;
          stored_total--;
          tree_adjust(32'(key), 1'b0);
        end
        res.rank = FIELD_W'(keys_below(32'(key)));
      end
      REQ_RANK: begin
        res.rank = FIELD_W'(keys_below(32'(key)));
      end
      default: begin
        if (idx >= stored_total) begin
          res.status = ST_RANGE;
        end else begin
          // walk down the tree for the smallest key whose running count passes idx
          pos  = 0;
          rem  = 32'(idx);
          step = NUM_KEYS;
          while (step > 0) begin
            if (pos + step <= NUM_KEYS && prefix_tree[pos + step] <= rem) begin
              pos = pos + step;
              rem = rem - prefix_tree[pos];
            end
            step = step >> 1;
          end
          res.selected_key = pos[FIELD_W-1:0];
          res.rank         = FIELD_W'(keys_below(32'(res.selected_key)));
        end
      end
    endcase
    res.total = stored_total;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      pending_results.push_back(apply_request(req_t'(s_tuser), s_tdata[FIELD_W-1:0],
                                              s_tdata[2*FIELD_W-1:FIELD_W]));
    end
  end

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string what, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing outstanding, got rank %0d total %0d key %0d st %0d",
                 $time, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser);
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("rank", 32'(oldest_result.rank), 32'(m_tdata[FIELD_W-1:0]));
        check_field("total", 32'(oldest_result.total), 32'(m_tdata[2*FIELD_W-1:FIELD_W]));
        check_field("selected_key", 32'(oldest_result.selected_key),
                    32'(m_tdata[3*FIELD_W-1:2*FIELD_W]));
        check_field("status", 32'(oldest_result.status), 32'(m_tuser));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (!receiver_idle_en) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_request(input req_t req, input logic [FIELD_W-1:0] key,
                              input logic [FIELD_W-1:0] idx);
    int gap;
    gap = sender_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {idx, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [FIELD_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return key_pool[$urandom_range(0, 15)];
    if (r < 65) return FIELD_W'($urandom_range(0, 7));
    if (r < 75) return FIELD_W'(16'hFFFF - $urandom_range(0, 7));
    return FIELD_W'($urandom());
  endfunction

  function automatic logic [FIELD_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && stored_total > 0) return FIELD_W'($urandom_range(0, stored_total - 1));
    if (r < 85) return stored_total;
    return FIELD_W'($urandom());
  endfunction

  task automatic send_random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) send_request(REQ_INSERT, pick_key(), FIELD_W'($urandom()));
    else if (r < 65) send_request(REQ_ERASE, pick_key(), FIELD_W'($urandom()));
    else if (r < 82) send_request(REQ_RANK, pick_key(), FIELD_W'($urandom()));
    else send_request(REQ_SELECT, FIELD_W'($urandom()), pick_index());
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    // empty store: rank, select and erase all see nothing
    send_request(REQ_RANK,   16'h0000, 16'h0000);
    send_request(REQ_RANK,   16'hFFFF, 16'hFFFF);
    send_request(REQ_SELECT, 16'h0000, 16'h0000);
    send_request(REQ_ERASE,  16'h0000, 16'h0000);
    send_request(REQ_ERASE,  16'hFFFF, 16'h0000);
    send_request(REQ_INSERT, 16'h0000, 16'h0000);
    send_request(REQ_INSERT, 16'hFFFF, 16'h0000);
    send_request(REQ_INSERT, 16'hFFFF, 16'h0000);
    send_request(REQ_INSERT, 16'h8000, 16'hFFFF);
    send_request(REQ_INSERT, 16'h5555, 16'hAAAA);
    send_request(REQ_RANK,   16'h0000, 16'h0000);
    send_request(REQ_RANK,   16'hFFFF, 16'h0000);
    send_request(REQ_RANK,   16'h8000, 16'h0000);
    send_request(REQ_RANK,   16'hAAAA, 16'h5555);
    send_request(REQ_SELECT, 16'hFFFF, 16'h0000);
    send_request(REQ_SELECT, 16'h0000, 16'h0001);
    // last valid position, then just past the end, then far past it
    send_request(REQ_SELECT, 16'h0000, 16'h0004);
    send_request(REQ_SELECT, 16'h0000, 16'h0005);
    send_request(REQ_SELECT, 16'h0000, 16'hFFFF);
    send_request(REQ_ERASE,  16'hFFFF, 16'h0000);
    send_request(REQ_ERASE,  16'hFFFF, 16'h0000);
    send_request(REQ_ERASE,  16'hFFFF, 16'h0000);
    send_request(REQ_ERASE,  16'h0000, 16'h0000);
    send_request(REQ_SELECT, 16'h1234, 16'h0000);
    send_request(REQ_RANK,   16'h0000, 16'h0000);
    drain();
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 16; i++) key_pool[i] = FIELD_W'($urandom());
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 0; i < 1300; i++) send_random_request();
    drain();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    sender_idle_en = 1'b0;
    hold_request   = 400;
    for (int i = 0; i < 40; i++) send_random_request();
    drain();
    sender_idle_en = 1'b1;
  endtask

  task automatic test_back_to_back();
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    for (int i = 0; i < 200; i++) send_random_request();
    drain();
    sender_idle_en   = 1'b1;
    receiver_idle_en = 1'b1;
  endtask

  // many copies of one key, then everything added here taken out again in random order
  task automatic test_fill_and_empty();
    logic [FIELD_W-1:0] added_keys [$];
    logic [FIELD_W-1:0] hot_key;
    int                 pos;
    hot_key = FIELD_W'($urandom());
    for (int i = 0; i < 120; i++) begin
      send_request(REQ_INSERT, hot_key, FIELD_W'($urandom()));
      added_keys.push_back(hot_key);
    end
    for (int i = 0; i < 60; i++) begin
      added_keys.push_back(pick_key());
      send_request(REQ_INSERT, added_keys[$], FIELD_W'($urandom()));
    end
    for (int i = 0; i < 10; i++) send_request(REQ_SELECT, FIELD_W'($urandom()), pick_index());
    while (added_keys.size() != 0) begin
      pos = $urandom_range(0, added_keys.size() - 1);
      send_request(REQ_ERASE, added_keys[pos], FIELD_W'($urandom()));
      added_keys.delete(pos);
    end
    drain();
    send_request(REQ_RANK, hot_key, 16'h0000);
    send_request(REQ_SELECT, hot_key, stored_total);
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix();
    test_backpressure();
    test_back_to_back();
    test_fill_and_empty();
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
